/* src/cmi_pkg.sv */
// Shared types, widths and the output formatting function of the complex 2x2
// matrix inverse core. Depends on nothing; every other file imports it.
package cmi_pkg;

  localparam int DW      = 16;             // width of one Q4.12 part
  localparam int PW      = 2 * DW;         // product of two parts
  localparam int DET_W   = 2 * DW + 2;     // Q10.24 determinant part, sum of four products
  localparam int EW      = DW + 1;         // element part after negation
  localparam int SQ_W    = 2 * DET_W - 2;  // |det|^2
  localparam int NP_W    = EW + DET_W;     // element part times determinant part
  localparam int NUM_W   = 50;             // numerator part, |value| <= 2^48
  localparam int MAG_W   = NUM_W - 1;      // numerator magnitude
  localparam int FRAC_SH = 25;             // 2^24 scaling plus one bit for rounding
  localparam int QW      = 16;             // quotient bits resolved by the divider
  localparam int REM_W   = SQ_W + 1 + QW;  // divisor 2|det|^2 shifted by QW
  localparam int LANES   = 8;              // four complex outputs, real and imaginary
  localparam int DIV_STG = QW + 2;         // dividend stage, overflow stage, one per bit

  typedef logic signed [DW-1:0]    s16_t;
  typedef logic signed [DET_W-1:0] det_t;
  typedef logic [MAG_W-1:0]        mag_t;
  typedef logic [SQ_W-1:0]         den_t;
  typedef logic [REM_W-1:0]        rem_t;

  typedef struct packed {
    s16_t a_re;
    s16_t a_im;
    s16_t b_re;
    s16_t b_im;
    s16_t c_re;
    s16_t c_im;
    s16_t d_re;
    s16_t d_im;
    logic skip;
  } mat_t;

  typedef struct packed {
    mat_t m;
    logic sing;
  } side_t;

  typedef struct packed {
    logic          ovf;
    logic          neg;
    logic [QW-1:0] q;
  } quo_t;

  localparam s16_t SAT_POS = {1'b0, {(DW - 1){1'b1}}};
  localparam s16_t SAT_NEG = {1'b1, {(DW - 1){1'b0}}};
  localparam logic [QW:0] LIM_POS = {2'b00, {(QW - 1){1'b1}}};
  localparam logic [QW:0] LIM_NEG = {2'b01, {(QW - 1){1'b0}}};

  // Applies the sign to a rounded quotient magnitude and saturates to Q4.12.
  function automatic s16_t fmt_quo(quo_t x);
    logic [QW:0] mag;
    logic [QW:0] neg_mag;
    s16_t        r;
    mag     = {1'b0, x.q};
    neg_mag = -mag;
    if (x.neg) begin
      if (x.ovf || (mag > LIM_NEG)) r = SAT_NEG;
      else r = s16_t'(neg_mag[DW-1:0]);
    end else begin
      if (x.ovf || (mag > LIM_POS)) r = SAT_POS;
      else r = s16_t'(mag[DW-1:0]);
    end
    return r;
  endfunction

endpackage

/* src/cmi_if.sv */
// Valid/ready channel interfaces for matrices in and inverses out.
// Depends on cmi_pkg for the part type.
interface cmi_in_if;
  import cmi_pkg::*;
  logic valid;
  logic ready;
  s16_t a_re;
  s16_t a_im;
  s16_t b_re;
  s16_t b_im;
  s16_t c_re;
  s16_t c_im;
  s16_t d_re;
  s16_t d_im;
  logic skip_flag;
  modport source (output valid, a_re, a_im, b_re, b_im, c_re, c_im, d_re, d_im,
                  skip_flag, input ready);
  modport sink (input valid, a_re, a_im, b_re, b_im, c_re, c_im, d_re, d_im,
                skip_flag, output ready);
endinterface

interface cmi_out_if;
  import cmi_pkg::*;
  logic valid;
  logic ready;
  s16_t p_re;
  s16_t p_im;
  s16_t q_re;
  s16_t q_im;
  s16_t r_re;
  s16_t r_im;
  s16_t s_re;
  s16_t s_im;
  logic skipped;
  logic singular;
  modport source (output valid, p_re, p_im, q_re, q_im, r_re, r_im, s_re, s_im,
                  skipped, singular, input ready);
  modport sink (input valid, p_re, p_im, q_re, q_im, r_re, r_im, s_re, s_im,
                skipped, singular, output ready);
endinterface

/* src/cmi_det.sv */
// Determinant stages: eight part products, then det = ad - bc in Q10.24.
// Depends on cmi_pkg.
module cmi_det (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_vld,
  input  cmi_pkg::mat_t in_mat,
  output logic          out_vld,
  output cmi_pkg::mat_t out_mat,
  output cmi_pkg::det_t det_re,
  output cmi_pkg::det_t det_im
);
  import cmi_pkg::*;

  logic                 vld1;
  mat_t                 mat1;
  logic signed [PW-1:0] prod [8];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      out_vld <= 1'b0;
    end else if (adv) begin
      vld1    <= in_vld;
      out_vld <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mat1    <= in_mat;
      prod[0] <= in_mat.a_re * in_mat.d_re;
      prod[1] <= in_mat.a_im * in_mat.d_im;
      prod[2] <= in_mat.b_re * in_mat.c_re;
      prod[3] <= in_mat.b_im * in_mat.c_im;
      prod[4] <= in_mat.a_re * in_mat.d_im;
      prod[5] <= in_mat.a_im * in_mat.d_re;
      prod[6] <= in_mat.b_re * in_mat.c_im;
      prod[7] <= in_mat.b_im * in_mat.c_re;
      out_mat <= mat1;
      det_re  <= DET_W'(prod[0]) - DET_W'(prod[1]) - DET_W'(prod[2]) + DET_W'(prod[3]);
      det_im  <= DET_W'(prod[4]) + DET_W'(prod[5]) - DET_W'(prod[6]) - DET_W'(prod[7]);
    end
  end

endmodule

/* src/cmi_norm.sv */
// Numerator and norm stages: |det|^2 and e * conj(det) for each element,
// then magnitude and sign of each numerator part. Depends on cmi_pkg.
module cmi_norm (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         in_vld,
  input  cmi_pkg::mat_t                in_mat,
  input  cmi_pkg::det_t                det_re,
  input  cmi_pkg::det_t                det_im,
  output logic                         out_vld,
  output cmi_pkg::side_t               out_side,
  output cmi_pkg::mag_t [cmi_pkg::LANES-1:0] mag,
  output logic [cmi_pkg::LANES-1:0]    neg,
  output cmi_pkg::den_t                den
);
  import cmi_pkg::*;

  logic signed [EW-1:0]      e_re [4];
  logic signed [EW-1:0]      e_im [4];
  logic signed [2*DET_W-1:0] sq_re_full;
  logic signed [2*DET_W-1:0] sq_im_full;
  logic signed [NP_W-1:0]    sum  [LANES];
  logic signed [NUM_W-1:0]   nabs [LANES];

  logic                   vld3, vld4;
  side_t                  side3, side4;
  den_t                   sq_re, sq_im, den4;
  logic signed [NP_W-1:0] pa [4];
  logic signed [NP_W-1:0] pb [4];
  logic signed [NP_W-1:0] pc [4];
  logic signed [NP_W-1:0] pd [4];
  logic signed [NUM_W-1:0] num [LANES];

  // Elements of the adjugate: d, -b, -c, a.
  always_comb begin
    e_re[0] = EW'(in_mat.d_re);
    e_im[0] = EW'(in_mat.d_im);
    e_re[1] = -EW'(in_mat.b_re);
    e_im[1] = -EW'(in_mat.b_im);
    e_re[2] = -EW'(in_mat.c_re);
    e_im[2] = -EW'(in_mat.c_im);
    e_re[3] = EW'(in_mat.a_re);
    e_im[3] = EW'(in_mat.a_im);
    sq_re_full = det_re * det_re;
    sq_im_full = det_im * det_im;
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sum[2*i]     = pa[i] + pb[i];
      sum[2*i + 1] = pc[i] - pd[i];
    end
    for (int l = 0; l < LANES; l++) begin
      nabs[l] = num[l][NUM_W-1] ? -num[l] : num[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3    <= 1'b0;
      vld4    <= 1'b0;
      out_vld <= 1'b0;
    end else if (adv) begin
      vld3    <= in_vld;
      vld4    <= vld3;
      out_vld <= vld4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side3.m    <= in_mat;
      side3.sing <= !in_mat.skip && (det_re == '0) && (det_im == '0);
      sq_re      <= sq_re_full[SQ_W-1:0];
      sq_im      <= sq_im_full[SQ_W-1:0];
      for (int i = 0; i < 4; i++) begin
        pa[i] <= e_re[i] * det_re;
        pb[i] <= e_im[i] * det_im;
        pc[i] <= e_im[i] * det_re;
        pd[i] <= e_re[i] * det_im;
      end
      side4 <= side3;
      den4  <= sq_re + sq_im;
      for (int l = 0; l < LANES; l++) begin
        num[l] <= sum[l][NUM_W-1:0];
      end
      out_side <= side4;
      den      <= den4;
      for (int l = 0; l < LANES; l++) begin
        neg[l] <= num[l][NUM_W-1];
        mag[l] <= nabs[l][MAG_W-1:0];
      end
    end
  end

endmodule

/* src/cmi_div.sv */
// Eight-lane pipelined restoring divider that gives round(mag * 2^24 / den),
// one quotient bit per stage, plus an overflow flag. Depends on cmi_pkg.
module cmi_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               adv,
  input  logic                               in_vld,
  input  cmi_pkg::side_t                     in_side,
  input  cmi_pkg::mag_t [cmi_pkg::LANES-1:0] mag,
  input  logic [cmi_pkg::LANES-1:0]          neg,
  input  cmi_pkg::den_t                      den,
  output logic                               out_vld,
  output cmi_pkg::side_t                     out_side,
  output cmi_pkg::quo_t [cmi_pkg::LANES-1:0] quo
);
  import cmi_pkg::*;

  logic [DIV_STG-1:0] vld_s;
  side_t              side_s [DIV_STG];
  den_t               den_s  [DIV_STG];
  logic [LANES-1:0]   neg_s  [DIV_STG];
  logic [LANES-1:0]   ovf_s  [1:DIV_STG-1];
  rem_t               rem_s  [DIV_STG][LANES];
  logic [QW-1:0]      q_s    [1:DIV_STG-1][LANES];
  logic [LANES-1:0]   ovf_cmp;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      ovf_cmp[l] = rem_s[0][l] >= (rem_t'(den_s[0]) << (QW + 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s <= '0;
    end else if (adv) begin
      vld_s <= {vld_s[DIV_STG-2:0], in_vld};
    end
  end

  // Side data, divisor, signs and overflow flags ride along with the item.
  always_ff @(posedge clk) begin
    if (adv) begin
      side_s[0] <= in_side;
      den_s[0]  <= den;
      neg_s[0]  <= neg;
      ovf_s[1]  <= ovf_cmp;
      for (int s = 1; s < DIV_STG; s++) begin
        side_s[s] <= side_s[s-1];
        den_s[s]  <= den_s[s-1];
        neg_s[s]  <= neg_s[s-1];
      end
      for (int s = 2; s < DIV_STG; s++) begin
        ovf_s[s] <= ovf_s[s-1];
      end
      // Dividend 2 * mag * 2^24 + den over divisor 2 * den rounds half up.
      for (int l = 0; l < LANES; l++) begin
        rem_s[0][l] <= (rem_t'(mag[l]) << FRAC_SH) + rem_t'(den);
        rem_s[1][l] <= rem_s[0][l];
        q_s[1][l]   <= '0;
      end
    end
  end

  for (genvar s = 2; s < DIV_STG; s++) begin : g_bit
    localparam int K = DIV_STG - 1 - s;
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      rem_t dsh;
      logic take;
      assign dsh  = rem_t'(den_s[s-1]) << (K + 1);
      assign take = rem_s[s-1][l] >= dsh;
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_s[s][l] <= take ? (rem_s[s-1][l] - dsh) : rem_s[s-1][l];
          q_s[s][l]   <= {q_s[s-1][l][QW-2:0], take};
        end
      end
    end
  end

  assign out_vld  = vld_s[DIV_STG-1];
  assign out_side = side_s[DIV_STG-1];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quo[l].ovf = ovf_s[DIV_STG-1][l];
      quo[l].neg = neg_s[DIV_STG-1][l];
      quo[l].q   = q_s[DIV_STG-1][l];
    end
  end

endmodule

/* src/complex_2x2_matrix_inverse_core.sv */
// Top level of the complex 2x2 matrix inverse core: channel ports, stall
// control and the output register. Depends on cmi_pkg, cmi_if, cmi_det,
// cmi_norm and cmi_div.

// The core takes one complex 2x2 matrix [[a, b], [c, d]] per item in signed
// Q4.12 and returns its inverse [[d, -b], [-c, a]] / det, with each part
// rounded to nearest (ties away from zero) and saturated to Q4.12. A matrix
// with skip_flag set comes out unchanged with skipped high; any other matrix
// whose determinant is exactly zero comes out as all zeros with singular
// high. The pipeline accepts one item in every cycle unless it is stalled,
// and its stages are those of the determinant, of the norm and the
// numerators, of the divider (dividend, overflow check, one quotient bit per
// stage in all eight lanes) and the output register. Every stage
// moves together, bubbles included: the pipeline holds everything, and the
// input is not ready, whenever the output register is full and not being
// taken in that cycle.
module complex_2x2_matrix_inverse_core (
  input logic       clk,
  input logic       rst,
  cmi_in_if.sink    mat_in,
  cmi_out_if.source inv_out
);
  import cmi_pkg::*;

  logic adv;
  mat_t in_mat;

  logic  det_vld;
  mat_t  det_mat;
  det_t  det_re, det_im;

  logic                    nrm_vld;
  side_t                   nrm_side;
  mag_t [LANES-1:0]        nrm_mag;
  logic [LANES-1:0]        nrm_neg;
  den_t                    nrm_den;

  logic                    div_vld;
  side_t                   div_side;
  quo_t [LANES-1:0]        div_quo;

  s16_t raw [LANES];
  s16_t res_next [LANES];

  // Output register.
  logic out_vld;
  s16_t res [LANES];
  logic skipped;
  logic singular;

  // The whole pipeline steps whenever the output register is free or is
  // being emptied in this cycle.
  assign adv          = !out_vld || inv_out.ready;
  assign mat_in.ready = adv;

  assign in_mat.a_re = mat_in.a_re;
  assign in_mat.a_im = mat_in.a_im;
  assign in_mat.b_re = mat_in.b_re;
  assign in_mat.b_im = mat_in.b_im;
  assign in_mat.c_re = mat_in.c_re;
  assign in_mat.c_im = mat_in.c_im;
  assign in_mat.d_re = mat_in.d_re;
  assign in_mat.d_im = mat_in.d_im;
  assign in_mat.skip = mat_in.skip_flag;

  cmi_det u_det (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (mat_in.valid),
    .in_mat  (in_mat),
    .out_vld (det_vld),
    .out_mat (det_mat),
    .det_re  (det_re),
    .det_im  (det_im)
  );

  cmi_norm u_norm (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (det_vld),
    .in_mat   (det_mat),
    .det_re   (det_re),
    .det_im   (det_im),
    .out_vld  (nrm_vld),
    .out_side (nrm_side),
    .mag      (nrm_mag),
    .neg      (nrm_neg),
    .den      (nrm_den)
  );

  cmi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (nrm_vld),
    .in_side  (nrm_side),
    .mag      (nrm_mag),
    .neg      (nrm_neg),
    .den      (nrm_den),
    .out_vld  (div_vld),
    .out_side (div_side),
    .quo      (div_quo)
  );

  // The original parts, in output order, for a skipped matrix.
  always_comb begin
    raw[0] = div_side.m.a_re;
    raw[1] = div_side.m.a_im;
    raw[2] = div_side.m.b_re;
    raw[3] = div_side.m.b_im;
    raw[4] = div_side.m.c_re;
    raw[5] = div_side.m.c_im;
    raw[6] = div_side.m.d_re;
    raw[7] = div_side.m.d_im;
    for (int l = 0; l < LANES; l++) begin
      if (div_side.m.skip) begin
        res_next[l] = raw[l];
      end else if (div_side.sing) begin
        res_next[l] = '0;
      end else begin
        res_next[l] = fmt_quo(div_quo[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res      <= res_next;
      skipped  <= div_side.m.skip;
      singular <= div_side.sing;
    end
  end

  assign inv_out.valid    = out_vld;
  assign inv_out.p_re     = res[0];
  assign inv_out.p_im     = res[1];
  assign inv_out.q_re     = res[2];
  assign inv_out.q_im     = res[3];
  assign inv_out.r_re     = res[4];
  assign inv_out.r_im     = res[5];
  assign inv_out.s_re     = res[6];
  assign inv_out.s_im     = res[7];
  assign inv_out.skipped  = skipped;
  assign inv_out.singular = singular;

  // A singular item always leaves with all parts zeroed.
  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    out_vld && singular |-> (res[0] == '0) && (res[1] == '0) && (res[2] == '0) &&
      (res[3] == '0) && (res[4] == '0) && (res[5] == '0) && (res[6] == '0) &&
      (res[7] == '0))
    else $error("singular item with nonzero parts");

  // The singular flag is only raised on items that were not skipped.
  a_skip_excl: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> !(skipped && singular))
    else $error("item marked both skipped and singular");

  // Nothing is offered in the cycle after reset.
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_vld)
    else $error("output valid right after reset");

endmodule
